[hdl/dtr_pkg.sv]
// Shared types, constants and rectangle helpers for the dirty rectangle tracker.
package dtr_pkg;

  localparam int COORD_BITS = 13;
  localparam int POS_W      = COORD_BITS + 1;
  localparam int SPAN_W     = POS_W + 1;
  localparam int AREA_W     = 2 * COORD_BITS;

  localparam logic [COORD_BITS-1:0] SCREEN_W_RST = COORD_BITS'(640);
  localparam logic [COORD_BITS-1:0] SCREEN_H_RST = COORD_BITS'(480);

  localparam logic OP_MARK  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic {
    REG_SCREEN_W = 1'b0,
    REG_SCREEN_H = 1'b1
  } reg_idx_t;

  // stored as corners: x0 < x1, y0 < y1, x1 and y1 exclusive, clipped to the screen
  typedef struct packed {
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x0;
  } rect_t;

  typedef struct packed {
    logic mul_en;
    logic cmp_en;
    logic first;
  } grow_ctl_t;

  // closed intervals, so shared edges count as touching
  function automatic logic touches(rect_t a, rect_t b);
    return (a.x0 <= b.x1) && (b.x0 <= a.x1) && (a.y0 <= b.y1) && (b.y0 <= a.y1);
  endfunction

  function automatic rect_t enclose(rect_t a, rect_t b);
    rect_t e;
    e.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
    e.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
    e.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
    e.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
    return e;
  endfunction

endpackage

[hdl/dtr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dtr_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/dtr_clip.sv]
// Clips a requested rectangle to the screen and flags an empty result.
module dtr_clip import dtr_pkg::*; (
  input  logic signed [POS_W-1:0]   rect_x,
  input  logic signed [POS_W-1:0]   rect_y,
  input  logic [COORD_BITS-1:0]     rect_width,
  input  logic [COORD_BITS-1:0]     rect_height,
  input  logic [COORD_BITS-1:0]     screen_w,
  input  logic [COORD_BITS-1:0]     screen_h,
  output rect_t                     clip,
  output logic                      empty
);

  logic signed [SPAN_W-1:0] xs, ys, xe, ye, x0, y0, xend, yend, xlim, ylim;

  always_comb begin
    xs   = SPAN_W'(rect_x);
    ys   = SPAN_W'(rect_y);
    xend = xs + $signed({2'b00, rect_width});
    yend = ys + $signed({2'b00, rect_height});
    xlim = $signed({2'b00, screen_w});
    ylim = $signed({2'b00, screen_h});
    xe   = (xend < xlim) ? xend : xlim;
    ye   = (yend < ylim) ? yend : ylim;
    x0   = (xs < 0) ? '0 : xs;
    y0   = (ys < 0) ? '0 : ys;
    empty   = (xe <= x0) || (ye <= y0);
    clip.x0 = x0[COORD_BITS-1:0];
    clip.y0 = y0[COORD_BITS-1:0];
    clip.x1 = xe[COORD_BITS-1:0];
    clip.y1 = ye[COORD_BITS-1:0];
  end

endmodule

[hdl/dtr_grow.sv]
// Area growth unit: registered products, then running minimum over the slots.
module dtr_grow import dtr_pkg::*; #(
  parameter int IDX_W = 3
) (
  input  logic             clk,
  input  grow_ctl_t        ctl,
  input  rect_t            r,
  input  rect_t            s,
  input  logic [IDX_W-1:0] idx,
  output logic [IDX_W-1:0] best_idx
);

  rect_t                 e;
  logic [COORD_BITS-1:0] ew, eh, sw, sh;
  logic [AREA_W-1:0]     area_e_r, area_s_r, best_g_r, growth;
  logic [IDX_W-1:0]      best_idx_r;

  always_comb begin
    e  = enclose(r, s);
    ew = e.x1 - e.x0;
    eh = e.y1 - e.y0;
    sw = s.x1 - s.x0;
    sh = s.y1 - s.y0;
    growth = area_e_r - area_s_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      area_e_r <= AREA_W'(ew) * AREA_W'(eh);
      area_s_r <= AREA_W'(sw) * AREA_W'(sh);
    end
    // strict less-than keeps the lowest index on ties
    if (ctl.cmp_en && (ctl.first || growth < best_g_r)) begin
      best_g_r   <= growth;
      best_idx_r <= idx;
    end
  end

  assign best_idx = best_idx_r;

endmodule

[hdl/dirty_rect_merge_tracker.sv]
// Top level: dirty rectangle list kept in a slot RAM, merged by a sequencer.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: op; tdata: x, y, width, height
//  out_    | out | out_tvalid/out_tready| tdata: x, y, width, height; tlast: last
//  cfg_    | in  | APB psel/penable     | reg 0 screen_width @0, reg 1 screen_height @4
//
// A mark is clipped; a merge pass starts in S_PEND, checks slots in S_CHK and refills each
// absorbed non-last slot in S_MOVE; passes repeat until nothing is absorbed, then S_PEND
// appends. A full list adds a growth scan of S_GMUL and S_GCMP per slot, then S_GSEL and a
// forced merge of the chosen slot. A flush gives one result per cycle while out_tready is
// high, the first via the RAM read and output registers. Reset (rst_n low, synchronous)
// empties the list; the RAM needs no clearing. Requests are taken only while idle; a stalled
// last result waits in the output register and does not block the next request.
module dirty_rect_merge_tracker import dtr_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // rect_x[13:0], rect_y[27:14], rect_width[40:28],
                                  // rect_height[53:41], zero pad
  input  logic        in_tuser,   // op: 0 mark, 1 flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_x[12:0], out_y[25:13], out_width[38:26],
                                  // out_height[51:39], zero pad
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_SLOTS);
  localparam int RW = $bits(rect_t);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLIP  = 9'b000000010,
    S_PEND  = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_MOVE  = 9'b000010000,
    S_GMUL  = 9'b000100000,
    S_GCMP  = 9'b001000000,
    S_GSEL  = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt;
  logic                    absorbed_r, absorbed_nxt;
  logic                    grow_r, grow_nxt;
  rect_t                   r_r, r_nxt;
  logic [COORD_BITS-1:0]   sw_r, sh_r;
  logic signed [POS_W-1:0] rect_x_r, rect_y_r;
  logic [COORD_BITS-1:0]   rect_w_r, rect_h_r;
  logic                    out_valid_r, out_valid_nxt, out_last_r, out_load;
  logic [COORD_BITS-1:0]   out_x_r, out_y_r, out_w_r, out_h_r;

  logic                    ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]        ram_wr_addr, ram_rd_addr;
  rect_t                   ram_wr_rect, rd_rect;
  logic [RW-1:0]           ram_rd_data;

  rect_t                   clip_rect;
  logic                    clip_empty;
  grow_ctl_t               gctl;
  logic [IDX_W-1:0]        best_idx;

  logic [CNT_W-1:0]        i_ext, ip1, cnt_m1;
  logic                    is_last, in_acc, cfg_wr;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign rd_rect    = rect_t'(ram_rd_data);

  assign i_ext   = CNT_W'(i_r);
  assign ip1     = i_ext + CNT_W'(1);
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign is_last = (i_ext == cnt_m1);

  dtr_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_rect),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  dtr_clip u_clip (
    .rect_x      (rect_x_r),
    .rect_y      (rect_y_r),
    .rect_width  (rect_w_r),
    .rect_height (rect_h_r),
    .screen_w    (sw_r),
    .screen_h    (sh_r),
    .clip        (clip_rect),
    .empty       (clip_empty)
  );

  dtr_grow #(.IDX_W(IDX_W)) u_grow (
    .clk      (clk),
    .ctl      (gctl),
    .r        (r_r),
    .s        (rd_rect),
    .idx      (i_r),
    .best_idx (best_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    absorbed_nxt  = absorbed_r;
    grow_nxt      = grow_r;
    r_nxt         = r_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = i_r;
    ram_wr_rect   = rd_rect;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = i_r;
    gctl          = '0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_FLUSH) begin
            if (cnt_r != '0) begin
              i_nxt       = '0;
              ram_rd_en   = 1'b1;
              ram_rd_addr = '0;
              state_nxt   = S_FLUSH;
            end
          end else begin
            state_nxt = S_CLIP;
          end
        end
      end
      S_CLIP: begin
        if (clip_empty) begin
          state_nxt = S_IDLE;
        end else begin
          r_nxt        = clip_rect;
          absorbed_nxt = 1'b1;   // forces the first merge pass
          grow_nxt     = 1'b0;
          state_nxt    = S_PEND;
        end
      end
      S_PEND: begin
        if (absorbed_r && cnt_r != '0) begin
          absorbed_nxt = 1'b0;
          i_nxt        = '0;
          ram_rd_en    = 1'b1;
          ram_rd_addr  = '0;
          state_nxt    = S_CHK;
        end else if (cnt_r == CNT_FULL) begin
          i_nxt       = '0;
          ram_rd_en   = 1'b1;
          ram_rd_addr = '0;
          state_nxt   = S_GMUL;
        end else begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = cnt_r[IDX_W-1:0];
          ram_wr_rect = r_r;
          cnt_nxt     = cnt_r + CNT_W'(1);
          state_nxt   = S_IDLE;
        end
      end
      S_CHK: begin
        if (grow_r || touches(r_r, rd_rect)) begin
          r_nxt        = enclose(r_r, rd_rect);
          absorbed_nxt = 1'b1;
          if (is_last) begin
            cnt_nxt   = cnt_m1;
            grow_nxt  = 1'b0;
            state_nxt = S_PEND;
          end else begin
            // fetch the last slot to fill the hole
            ram_rd_en   = 1'b1;
            ram_rd_addr = cnt_m1[IDX_W-1:0];
            state_nxt   = S_MOVE;
          end
        end else if (ip1 < cnt_r) begin
          i_nxt       = ip1[IDX_W-1:0];
          ram_rd_en   = 1'b1;
          ram_rd_addr = ip1[IDX_W-1:0];
        end else begin
          state_nxt = S_PEND;
        end
      end
      S_MOVE: begin
        ram_wr_en = 1'b1;
        cnt_nxt   = cnt_m1;
        if (grow_r) begin
          grow_nxt  = 1'b0;
          state_nxt = S_PEND;
        end else if (ip1 < cnt_m1) begin
          // moved slot is skipped in this pass; address differs from the write
          i_nxt       = ip1[IDX_W-1:0];
          ram_rd_en   = 1'b1;
          ram_rd_addr = ip1[IDX_W-1:0];
          state_nxt   = S_CHK;
        end else begin
          state_nxt = S_PEND;
        end
      end
      S_GMUL: begin
        gctl.mul_en = 1'b1;
        state_nxt   = S_GCMP;
      end
      S_GCMP: begin
        gctl.cmp_en = 1'b1;
        gctl.first  = (i_r == '0);
        if (ip1 < cnt_r) begin
          i_nxt       = ip1[IDX_W-1:0];
          ram_rd_en   = 1'b1;
          ram_rd_addr = ip1[IDX_W-1:0];
          state_nxt   = S_GMUL;
        end else begin
          state_nxt = S_GSEL;
        end
      end
      S_GSEL: begin
        i_nxt       = best_idx;
        ram_rd_en   = 1'b1;
        ram_rd_addr = best_idx;
        grow_nxt    = 1'b1;
        state_nxt   = S_CHK;
      end
      S_FLUSH: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (is_last) begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            i_nxt       = ip1[IDX_W-1:0];
            ram_rd_en   = 1'b1;
            ram_rd_addr = ip1[IDX_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      i_r         <= '0;
      absorbed_r  <= 1'b0;
      grow_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sw_r        <= SCREEN_W_RST;
      sh_r        <= SCREEN_H_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      absorbed_r  <= absorbed_nxt;
      grow_r      <= grow_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (reg_idx_t'(cfg_paddr[2]))
          REG_SCREEN_W: sw_r <= cfg_pwdata[COORD_BITS-1:0];
          REG_SCREEN_H: sh_r <= cfg_pwdata[COORD_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    if (in_acc) begin
      rect_x_r <= in_tdata[13:0];
      rect_y_r <= in_tdata[27:14];
      rect_w_r <= in_tdata[40:28];
      rect_h_r <= in_tdata[53:41];
    end
    if (out_load) begin
      out_x_r    <= rd_rect.x0;
      out_y_r    <= rd_rect.y0;
      out_w_r    <= rd_rect.x1 - rd_rect.x0;
      out_h_r    <= rd_rect.y1 - rd_rect.y0;
      out_last_r <= is_last;
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[2]))
      REG_SCREEN_W: cfg_prdata = 32'(sw_r);
      REG_SCREEN_H: cfg_prdata = 32'(sh_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_h_r, out_w_r, out_y_r, out_x_r};

endmodule
